// File: src/phfe_pkg.sv
// ----------------------------------------------------------------------------
// phfe_pkg
// Shared constants and the summary_t type for the header field extractor.
// ----------------------------------------------------------------------------
package phfe_pkg;
  localparam logic [15:0] KIND_VLAN = 16'h8100;
  localparam logic [15:0] KIND_IPV4 = 16'h0800;
  localparam logic [15:0] KIND_IPV6 = 16'h86DD;
  localparam logic [15:0] KIND_ARP = 16'h0806;
  localparam logic [7:0] ARP_CODE = 8'd205;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [31:0] FAMILY_V4 = 32'd2;
  localparam logic [31:0] FAMILY_V6 = 32'd24;
  localparam logic [4:0] ETH_LEN = 5'd14;
  localparam logic [4:0] VLAN_ETH_LEN = 5'd18;
  localparam logic [4:0] LOOP_LEN = 5'd4;
  localparam logic [6:0] IPV6_LEN = 7'd40;
  localparam logic [6:0] SMALL_HDR = 7'd8;

  typedef struct packed {
    logic [7:0]  protocol;
    logic        is_ipv6;
    logic [15:0] l4_src;
    logic [15:0] l4_dst;
    logic [7:0]  flag_bits;
    logic [15:0] body_len;
    logic [63:0] src_ip_hi;
    logic [63:0] src_ip_lo;
    logic [63:0] dst_ip_hi;
    logic [63:0] dst_ip_lo;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
  } summary_t;
endpackage

// File: src/packet_header_field_extractor.sv
// ----------------------------------------------------------------------------
// packet_header_field_extractor
// Parses link, network and transport headers of a byte stream into a summary.
// ----------------------------------------------------------------------------
// channel  | signals                           | direction
// in       | in_valid, in_stall, data_byte ... | into block
// out      | out_valid, out_stall, protocol... | out of block
// cfg      | cfg_we, cfg_data                  | into block
// One byte is accepted per cycle while in_stall is low; the summary of a frame
// is registered at the edge that accepts its last byte and offered from the
// next cycle. Synchronous reset clears all frame state and link_type. in_stall
// is high only while a summary waits and out_stall holds it.
module packet_header_field_extractor
  import phfe_pkg::*;
#(
  parameter int PAYLOAD_CAP = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  protocol,
  output logic        is_ipv6,
  output logic [15:0] l4_src,
  output logic [15:0] l4_dst,
  output logic [7:0]  flag_bits,
  output logic [15:0] body_len,
  output logic [63:0] src_ip_hi,
  output logic [63:0] src_ip_lo,
  output logic [63:0] dst_ip_hi,
  output logic [63:0] dst_ip_lo,
  output logic [47:0] src_mac,
  output logic [47:0] dst_mac
);
  localparam logic [16:0] CAP = 17'(PAYLOAD_CAP);

  logic link_type;
  logic [15:0] byte_position;
  logic [4:0] network_start;
  logic [15:0] ether_kind;
  logic [6:0] transport_start;
  logic [31:0] family_word;
  logic [63:0] cf [8];
  logic ts_valid;
  logic [7:0] proto_num;
  logic [15:0] arp_oper;
  summary_t res;

  logic acc;
  assign in_stall = out_valid && out_stall;
  assign acc = in_valid && !in_stall;

  // next-state values
  logic [4:0] ns_n;
  logic [15:0] ek_n;
  logic [6:0] ts_n;
  logic [31:0] fw_n;
  logic [63:0] cf_n [8];
  logic tsv_n;
  logic [7:0] pn_n;
  logic [15:0] ao_n;
  logic [15:0] rel;
  logic [15:0] trel;
  logic [2:0] sh;
  logic [7:0] tb [14];
  logic [6:0] thl;
  logic has_hdr;
  logic [16:0] caplen, endp, plen;
  summary_t sum;

  always_comb begin
    ns_n = network_start;
    ek_n = ether_kind;
    ts_n = transport_start;
    fw_n = family_word;
    for (int i = 0; i < 8; i++) cf_n[i] = cf[i];
    tsv_n = ts_valid;
    pn_n = proto_num;
    ao_n = arp_oper;
    sh = 3'd0;
    if (byte_position == 16'd0) ns_n = link_type ? LOOP_LEN : ETH_LEN;
    if (!link_type) begin
      if (byte_position < 16'd6) begin
        sh = 3'(5 - byte_position[2:0]);
        cf_n[5][sh*8 +: 8] = data_byte;
      end else if (byte_position < 16'd12) begin
        sh = 3'(11 - byte_position[3:0]);
        cf_n[4][sh*8 +: 8] = data_byte;
      end
      if (byte_position >= 16'd12 && byte_position <= 16'd17)
        fw_n = {family_word[23:0], data_byte};
      if (byte_position == 16'd13) begin
        ek_n = fw_n[15:0];
        if (ek_n == KIND_ARP) begin
          cf_n[4] = '0;
          cf_n[5] = '0;
        end
        if (ek_n == KIND_VLAN) ns_n = VLAN_ETH_LEN;
      end else if (byte_position == 16'd17 && ns_n == VLAN_ETH_LEN) begin
        ek_n = fw_n[15:0];
        if (ek_n == KIND_ARP) begin
          cf_n[4] = '0;
          cf_n[5] = '0;
        end
      end
    end else if (byte_position < 16'd4) begin
      fw_n[byte_position[1:0]*8 +: 8] = data_byte;
      if (byte_position == 16'd3) begin
        if (fw_n == FAMILY_V4) ek_n = KIND_IPV4;
        else if (fw_n == FAMILY_V6) ek_n = KIND_IPV6;
        else ek_n = '0;
      end
    end
    rel = byte_position - 16'(ns_n);
    if (byte_position >= 16'(ns_n)) begin
      if (ek_n == KIND_IPV4) begin
        if (rel == 16'd0) begin
          ts_n = 7'(ns_n) + {1'b0, data_byte[3:0], 2'b00};
          tsv_n = 1'b1;
        end else if (rel == 16'd9) pn_n = data_byte;
        else if (rel >= 16'd12 && rel < 16'd16)
          cf_n[0][(7 - rel[1:0])*8 +: 8] = data_byte;
        else if (rel >= 16'd16 && rel < 16'd20)
          cf_n[2][(7 - rel[1:0])*8 +: 8] = data_byte;
      end else if (ek_n == KIND_IPV6) begin
        if (rel == 16'd0) begin
          ts_n = 7'(ns_n) + IPV6_LEN;
          tsv_n = 1'b1;
        end else if (rel == 16'd6) pn_n = data_byte;
        else if (rel >= 16'd8 && rel < 16'd24)
          cf_n[{2'b00, rel[4]}][(7 - rel[2:0])*8 +: 8] = data_byte;
        else if (rel >= 16'd24 && rel < 16'd40)
          cf_n[{2'b01, ~rel[4]}][(7 - rel[2:0])*8 +: 8] = data_byte;
      end else if (ek_n == KIND_ARP) begin
        if (rel == 16'd6) ao_n[15:8] = data_byte;
        else if (rel == 16'd7) ao_n[7:0] = data_byte;
        else if (rel >= 16'd8 && rel < 16'd14)
          cf_n[4][3'(13 - rel[3:0])*8 +: 8] = data_byte;
        else if (rel >= 16'd14 && rel < 16'd18)
          cf_n[0][(7 - 3'(rel[3:0] - 4'd14))*8 +: 8] = data_byte;
        else if (rel >= 16'd18 && rel < 16'd24)
          cf_n[5][3'(23 - rel[4:0])*8 +: 8] = data_byte;
        else if (rel >= 16'd24 && rel < 16'd28)
          cf_n[2][(7 - rel[1:0])*8 +: 8] = data_byte;
      end
    end
    trel = byte_position - 16'(ts_n);
    if (tsv_n && byte_position >= 16'(ts_n) && trel < 16'd14)
      cf_n[{2'b11, trel[3]}][(7 - trel[2:0])*8 +: 8] = data_byte;

    // summary for a last byte
    for (int k = 0; k < 14; k++)
      tb[k] = cf_n[6 + k/8][(7 - k%8)*8 +: 8];
    caplen = 17'(byte_position) + 17'd1;
    sum = '0;
    thl = '0;
    has_hdr = 1'b0;
    plen = '0;
    endp = '0;
    if (ek_n == KIND_IPV4 || ek_n == KIND_IPV6) begin
      sum.protocol = pn_n;
      sum.is_ipv6 = (ek_n == KIND_IPV6);
      if ((sum.is_ipv6 && pn_n == PROTO_ICMPV6) || pn_n == PROTO_ICMP) begin
        sum.l4_src = {8'd0, tb[0]};
        sum.l4_dst = {8'd0, tb[1]};
        thl = SMALL_HDR;
        has_hdr = 1'b1;
      end else if (pn_n == PROTO_TCP || pn_n == PROTO_UDP) begin
        sum.l4_src = {tb[0], tb[1]};
        sum.l4_dst = {tb[2], tb[3]};
        if (pn_n == PROTO_TCP) begin
          sum.flag_bits = tb[13];
          thl = {1'b0, tb[12][7:4], 2'b00};
        end else thl = SMALL_HDR;
        has_hdr = 1'b1;
      end
      if (has_hdr && tsv_n) begin
        endp = 17'(ts_n) + 17'(thl);
        if (caplen > endp) plen = caplen - endp;
        if (plen > CAP) plen = CAP;
      end
      sum.body_len = plen[15:0];
    end else if (ek_n == KIND_ARP) begin
      sum.protocol = ARP_CODE;
      sum.l4_src = ao_n;
    end
    if (ek_n == KIND_IPV4 || ek_n == KIND_IPV6 || ek_n == KIND_ARP) begin
      sum.src_ip_hi = cf_n[0];
      sum.src_ip_lo = cf_n[1];
      sum.dst_ip_hi = cf_n[2];
      sum.dst_ip_lo = cf_n[3];
    end
    sum.src_mac = cf_n[4][47:0];
    sum.dst_mac = cf_n[5][47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_type <= 1'b0;
      byte_position <= '0;
      network_start <= '0;
      ether_kind <= '0;
      transport_start <= '0;
      family_word <= '0;
      for (int i = 0; i < 8; i++) cf[i] <= '0;
      ts_valid <= 1'b0;
      proto_num <= '0;
      arp_oper <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) link_type <= cfg_data;
      if (acc && last_byte) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (acc) begin
        if (last_byte) begin
          byte_position <= '0;
          network_start <= '0;
          ether_kind <= '0;
          transport_start <= '0;
          family_word <= '0;
          for (int i = 0; i < 8; i++) cf[i] <= '0;
          ts_valid <= 1'b0;
          proto_num <= '0;
          arp_oper <= '0;
        end else begin
          if (byte_position != 16'hFFFF) byte_position <= byte_position + 16'd1;
          network_start <= ns_n;
          ether_kind <= ek_n;
          transport_start <= ts_n;
          family_word <= fw_n;
          for (int i = 0; i < 8; i++) cf[i] <= cf_n[i];
          ts_valid <= tsv_n;
          proto_num <= pn_n;
          arp_oper <= ao_n;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && last_byte) res <= sum;
  end

  assign protocol = res.protocol;
  assign is_ipv6 = res.is_ipv6;
  assign l4_src = res.l4_src;
  assign l4_dst = res.l4_dst;
  assign flag_bits = res.flag_bits;
  assign body_len = res.body_len;
  assign src_ip_hi = res.src_ip_hi;
  assign src_ip_lo = res.src_ip_lo;
  assign dst_ip_hi = res.dst_ip_hi;
  assign dst_ip_lo = res.dst_ip_lo;
  assign src_mac = res.src_mac;
  assign dst_mac = res.dst_mac;

`ifndef NO_ASSERTIONS
  a_last_sets_valid: assert property (@(posedge clk) disable iff (rst)
    acc && last_byte |=> out_valid) else $error("summary missing");
  a_stall_only_when_held: assert property (@(posedge clk)
    in_stall |-> out_valid) else $error("stall without summary");
  a_pos_clears: assert property (@(posedge clk) disable iff (rst)
    acc && last_byte |=> byte_position == 16'd0) else $error("position kept");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 17'(body_len) <= CAP) else $error("payload above cap");
`endif
endmodule

// File: dv/tb_packet_header_field_extractor.sv
// ----------------------------------------------------------------------------
// tb_packet_header_field_extractor
// Self-checking bench for the packet header field extractor. A directed table
// of frames runs first, then random well-formed and broken frames under both
// link types and three idling patterns. Every frame summary is compared field
// by field with the table's summary or a cycle-free predictor of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_packet_header_field_extractor;
  import phfe_pkg::*;

  localparam int CAP = 2048;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  summary_t    got;

  packet_header_field_extractor #(.PAYLOAD_CAP(CAP)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .protocol(got.protocol), .is_ipv6(got.is_ipv6),
    .l4_src(got.l4_src), .l4_dst(got.l4_dst),
    .flag_bits(got.flag_bits), .body_len(got.body_len),
    .src_ip_hi(got.src_ip_hi), .src_ip_lo(got.src_ip_lo),
    .dst_ip_hi(got.dst_ip_hi), .dst_ip_lo(got.dst_ip_lo),
    .src_mac(got.src_mac), .dst_mac(got.dst_mac)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end

  // predictor state
  bit          link_type;
  logic [15:0] frame_pos;
  int unsigned net_start;
  logic [15:0] kind;
  int unsigned trans_start;
  logic [31:0] fam;
  logic [63:0] fields [8];
  bit          trans_ok;
  logic [7:0]  proto_num;
  logic [15:0] arp_op;

  summary_t    summary_q[$];
  int          errors;
  int          n_items;
  int          n_frames;
  int          idle_in;
  int          stall_out;

  function automatic void clear_frame();
    frame_pos = '0; net_start = 0; kind = '0; trans_start = 0; fam = '0;
    foreach (fields[i]) fields[i] = '0;
    trans_ok = 1'b0; proto_num = '0; arp_op = '0;
  endfunction

  function automatic void put_addr(int unsigned w, int unsigned k, logic [7:0] b);
    k = k % 16;
    fields[w + k / 8][(7 - k % 8) * 8 +: 8] = b;
  endfunction

  function automatic logic [7:0] trans_byte(int unsigned k);
    if (k >= 14) return 8'h00;
    return fields[6 + k / 8][(7 - k % 8) * 8 +: 8];
  endfunction

  function automatic void set_kind(logic [15:0] k);
    kind = k;
    if (kind == KIND_ARP) begin
      fields[4] = '0;
      fields[5] = '0;
    end
  endfunction

  function automatic void net_byte(int unsigned rel, logic [7:0] b);
    if (kind == KIND_IPV4) begin
      if (rel == 0) begin
        trans_start = (net_start + b[3:0] * 4) % 128;
        trans_ok = 1'b1;
      end else if (rel == 9) proto_num = b;
      else if (rel >= 12 && rel < 16) put_addr(0, rel - 12, b);
      else if (rel >= 16 && rel < 20) put_addr(2, rel - 16, b);
    end else if (kind == KIND_IPV6) begin
      if (rel == 0) begin
        trans_start = (net_start + IPV6_LEN) % 128;
        trans_ok = 1'b1;
      end else if (rel == 6) proto_num = b;
      else if (rel >= 8 && rel < 24) put_addr(0, rel - 8, b);
      else if (rel >= 24 && rel < 40) put_addr(2, rel - 24, b);
    end else if (kind == KIND_ARP) begin
      if (rel == 6) arp_op[15:8] = b;
      else if (rel == 7) arp_op[7:0] = b;
      else if (rel >= 8 && rel < 14) fields[4][(13 - rel) * 8 +: 8] = b;
      else if (rel >= 14 && rel < 18) put_addr(0, rel - 14, b);
      else if (rel >= 18 && rel < 24) fields[5][(23 - rel) * 8 +: 8] = b;
      else if (rel >= 24 && rel < 28) put_addr(2, rel - 24, b);
    end
  endfunction

  // advance the parser by one byte; returns 1 with the summary at frame end
  function automatic bit parse_byte(logic [7:0] b, bit lst, output summary_t s);
    int unsigned pos, k, caplen, hlen, fin;
    bit has_hdr;
    pos = frame_pos;
    s = '0;
    if (pos == 0) net_start = link_type ? LOOP_LEN : ETH_LEN;
    if (!link_type) begin
      if (pos < 6) fields[5][(5 - pos) * 8 +: 8] = b;
      else if (pos < 12) fields[4][(11 - pos) * 8 +: 8] = b;
      if (pos >= 12 && pos <= 17) fam = {fam[23:0], b};
      if (pos == 13) begin
        set_kind(fam[15:0]);
        if (kind == KIND_VLAN) net_start = VLAN_ETH_LEN;
      end else if (pos == 17 && net_start == VLAN_ETH_LEN) begin
        set_kind(fam[15:0]);
      end
    end else if (pos < 4) begin
      fam[pos * 8 +: 8] = b;
      if (pos == 3) begin
        if (fam == FAMILY_V4) kind = KIND_IPV4;
        else if (fam == FAMILY_V6) kind = KIND_IPV6;
        else kind = '0;
      end
    end
    if (pos >= net_start) net_byte(pos - net_start, b);
    if (trans_ok && pos >= trans_start && pos - trans_start < 14) begin
      k = pos - trans_start;
      fields[6 + k / 8][(7 - k % 8) * 8 +: 8] = b;
    end
    if (frame_pos != 16'hFFFF) frame_pos++;
    if (!lst) return 1'b0;

    caplen = pos + 1;
    hlen = 0;
    has_hdr = 1'b0;
    if (kind == KIND_IPV4 || kind == KIND_IPV6) begin
      s.protocol = proto_num;
      s.is_ipv6 = (kind == KIND_IPV6);
      if ((s.is_ipv6 && proto_num == PROTO_ICMPV6) || proto_num == PROTO_ICMP) begin
        s.l4_src = {8'h00, trans_byte(0)};
        s.l4_dst = {8'h00, trans_byte(1)};
        hlen = SMALL_HDR;
        has_hdr = 1'b1;
      end else if (proto_num == PROTO_TCP || proto_num == PROTO_UDP) begin
        s.l4_src = {trans_byte(0), trans_byte(1)};
        s.l4_dst = {trans_byte(2), trans_byte(3)};
        if (proto_num == PROTO_TCP) begin
          s.flag_bits = trans_byte(13);
          hlen = (trans_byte(12) >> 4) * 4;
        end else begin
          hlen = SMALL_HDR;
        end
        has_hdr = 1'b1;
      end
      if (has_hdr && trans_ok) begin
        fin = trans_start + hlen;
        if (caplen > fin) s.body_len = 16'((caplen - fin > CAP) ? CAP : caplen - fin);
      end
    end else if (kind == KIND_ARP) begin
      s.protocol = ARP_CODE;
      s.l4_src = arp_op;
    end else begin
      for (int i = 0; i < 4; i++) fields[i] = '0;
    end
    s.src_ip_hi = fields[0];
    s.src_ip_lo = fields[1];
    s.dst_ip_hi = fields[2];
    s.dst_ip_lo = fields[3];
    s.src_mac = fields[4][47:0];
    s.dst_mac = fields[5][47:0];
    clear_frame();
    return 1'b1;
  endfunction

  task automatic report(string what, logic [63:0] g, logic [63:0] e);
    $display("mismatch %s: got %h expected %h", what, g, e);
    errors++;
  endtask

  // result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_out);
  end

  always @(posedge clk) begin
    summary_t e;
    if (!rst && out_valid && !out_stall) begin
      if (summary_q.size() == 0) begin
        report("unexpected summary", 64'(got.protocol), 64'd0);
      end else begin
        e = summary_q.pop_front();
        if (got.protocol !== e.protocol)
          report("protocol", 64'(got.protocol), 64'(e.protocol));
        if (got.is_ipv6 !== e.is_ipv6)
          report("is_ipv6", 64'(got.is_ipv6), 64'(e.is_ipv6));
        if (got.l4_src !== e.l4_src) report("l4_src", 64'(got.l4_src), 64'(e.l4_src));
        if (got.l4_dst !== e.l4_dst) report("l4_dst", 64'(got.l4_dst), 64'(e.l4_dst));
        if (got.flag_bits !== e.flag_bits)
          report("flag_bits", 64'(got.flag_bits), 64'(e.flag_bits));
        if (got.body_len !== e.body_len)
          report("body_len", 64'(got.body_len), 64'(e.body_len));
        if (got.src_ip_hi !== e.src_ip_hi) report("src_ip_hi", got.src_ip_hi, e.src_ip_hi);
        if (got.src_ip_lo !== e.src_ip_lo) report("src_ip_lo", got.src_ip_lo, e.src_ip_lo);
        if (got.dst_ip_hi !== e.dst_ip_hi) report("dst_ip_hi", got.dst_ip_hi, e.dst_ip_hi);
        if (got.dst_ip_lo !== e.dst_ip_lo) report("dst_ip_lo", got.dst_ip_lo, e.dst_ip_lo);
        if (got.src_mac !== e.src_mac)
          report("src_mac", 64'(got.src_mac), 64'(e.src_mac));
        if (got.dst_mac !== e.dst_mac)
          report("dst_mac", 64'(got.dst_mac), 64'(e.dst_mac));
      end
    end
  end

  // item side
  task automatic send_item(logic [7:0] b, bit lst, bit typed, summary_t typed_sum);
    summary_t s;
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (in_stall);
    n_items++;
    if (parse_byte(b, lst, s)) begin
      n_frames++;
      summary_q.push_back(typed ? typed_sum : s);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_link(bit v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    link_type = v;
  endtask

  function automatic logic [7:0] pick_proto();
    int c;
    c = $urandom_range(9);
    if (c < 3) return PROTO_TCP;
    if (c < 6) return PROTO_UDP;
    if (c < 7) return PROTO_ICMP;
    if (c < 8) return PROTO_ICMPV6;
    return 8'($urandom);
  endfunction

  function automatic void build_frame(ref logic [7:0] fr[$], input int pay);
    int c, ihl, off;
    logic [15:0] k;
    logic [31:0] f;
    logic [7:0] pr;
    fr.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 60)) fr.push_back(8'($urandom));
      return;
    end
    c = $urandom_range(19);
    if (!link_type) begin
      repeat (12) fr.push_back(8'($urandom));
      if ($urandom_range(3) == 0) begin
        fr.push_back(KIND_VLAN[15:8]); fr.push_back(KIND_VLAN[7:0]);
        fr.push_back(8'($urandom)); fr.push_back(8'($urandom));
      end
      k = c < 8 ? KIND_IPV4 : c < 14 ? KIND_IPV6 : c < 18 ? KIND_ARP :
          c < 19 ? KIND_VLAN : 16'($urandom);
      fr.push_back(k[15:8]); fr.push_back(k[7:0]);
    end else begin
      f = c < 10 ? FAMILY_V4 : c < 18 ? FAMILY_V6 : $urandom_range(0, 30);
      for (int i = 0; i < 4; i++) fr.push_back(f[i * 8 +: 8]);
      k = f == FAMILY_V4 ? KIND_IPV4 : f == FAMILY_V6 ? KIND_IPV6 : 16'h0000;
    end
    pr = pick_proto();
    if (k == KIND_IPV4) begin
      ihl = $urandom_range(7) == 0 ? $urandom_range(15) : 5;
      fr.push_back({4'h4, 4'(ihl)});
      repeat (8) fr.push_back(8'($urandom));
      fr.push_back(pr);
      repeat (10 + (ihl > 5 ? (ihl - 5) * 4 : 0)) fr.push_back(8'($urandom));
    end else if (k == KIND_IPV6) begin
      repeat (6) fr.push_back(8'($urandom));
      fr.push_back(pr);
      repeat (33) fr.push_back(8'($urandom));
    end else if (k == KIND_ARP) begin
      repeat (6) fr.push_back(8'($urandom));
      fr.push_back($urandom_range(1) ? 8'h00 : 8'($urandom));
      fr.push_back(8'($urandom));
      repeat (20) fr.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(20)) fr.push_back(8'($urandom));
    end
    if (pr == PROTO_TCP) begin
      off = $urandom_range(7) == 0 ? $urandom_range(15) : 5;
      repeat (12) fr.push_back(8'($urandom));
      fr.push_back({4'(off), 4'($urandom)});
      fr.push_back(8'($urandom));
      repeat (6 + (off > 5 ? (off - 5) * 4 : 0)) fr.push_back(8'($urandom));
    end else begin
      repeat (8) fr.push_back(8'($urandom));
    end
    repeat (pay) fr.push_back(8'($urandom));
    if ($urandom_range(5) == 0) begin
      c = $urandom_range(1, fr.size());
      while (fr.size() > c) void'(fr.pop_back());
    end
  endfunction

  task automatic send_frame(int pay);
    logic [7:0] fr[$];
    build_frame(fr, pay);
    foreach (fr[i]) send_item(fr[i], i == fr.size() - 1, 1'b0, '0);
  endtask

  typedef struct {
    logic [7:0] b;
    bit         lst;
    bit         typed;
    summary_t   sum;
  } row_t;

  initial begin
    row_t     tab[$];
    row_t     r;
    summary_t z;
    int       goal;
    clear_frame();
    link_type = 1'b0;
    errors = 0; n_items = 0; n_frames = 0;
    idle_in = 35; stall_out = 46;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // one-byte frames after reset, then a short arp request
    z = '0;
    r = '{8'hFF, 1'b1, 1'b1, z}; r.sum.dst_mac = 48'hFF00_0000_0000; tab.push_back(r);
    r = '{8'h00, 1'b1, 1'b1, z}; tab.push_back(r);
    for (int i = 0; i < 12; i++) tab.push_back('{8'hFF, 1'b0, 1'b0, z});
    tab.push_back('{KIND_ARP[15:8], 1'b0, 1'b0, z});
    tab.push_back('{KIND_ARP[7:0], 1'b0, 1'b0, z});
    for (int i = 0; i < 6; i++) tab.push_back('{8'($urandom), 1'b0, 1'b0, z});
    tab.push_back('{8'h00, 1'b0, 1'b0, z});
    r = '{8'h01, 1'b1, 1'b1, z}; r.sum.protocol = ARP_CODE; r.sum.l4_src = 16'h0001;
    tab.push_back(r);
    foreach (tab[i]) send_item(tab[i].b, tab[i].lst, tab[i].typed, tab[i].sum);

    for (int ph = 0; ph < 6; ph++) begin
      set_link(ph % 2);
      idle_in = ph < 2 ? 35 : ph < 4 ? 46 : 0;
      stall_out = ph < 2 ? 46 : ph < 4 ? 35 : 0;
      goal = n_items + 320;
      while (n_items < goal) begin
        send_frame($urandom_range(0, 24));
        if ($urandom_range(15) == 0) drain();
      end
      drain();
    end

    drain();
    repeat (10) @(posedge clk);
    $display("%0d bytes in %0d frames, both link types, three idling patterns",
             n_items, n_frames);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/phfe_pkg.sv
src/packet_header_field_extractor.sv
dv/tb_packet_header_field_extractor.sv
